### design/topological_sort_kahn_top_macros.svh
// ----------------------------------------------------------------------------
// Topological sort assertion macros
// Concurrent assertion wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TOPOLOGICAL_SORT_KAHN_TOP_MACROS_SVH
`define TOPOLOGICAL_SORT_KAHN_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TSK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define TSK_ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition");
`else
`define TSK_ASSERT(label, clk, rst_n, prop)
`define TSK_ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

### design/tsk_pkg.sv
// ----------------------------------------------------------------------------
// Topological sort package
// Sizes and shared types.
// ----------------------------------------------------------------------------
package tsk_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 1024;
  localparam int VW = $clog2(MaxVertices);
  localparam int EW = $clog2(MaxEdges);
  localparam int DW = EW + 1;

  typedef enum logic [8:0] {
    ST_LOAD   = 9'b000000001,
    ST_SEED   = 9'b000000010,
    ST_POP    = 9'b000000100,
    ST_POPRD  = 9'b000001000,
    ST_EMIT   = 9'b000010000,
    ST_EDGE   = 9'b000100000,
    ST_DEC    = 9'b001000000,
    ST_FINAL  = 9'b010000000,
    ST_CLEAR  = 9'b100000000
  } state_e;

  typedef struct packed {
    logic [6:0] vertex;
    logic       vertex_valid;
    logic       last_result;
    logic       cycle_found;
    logic       order_unique;
    logic       input_dropped;
  } result_t;
endpackage

### design/topological_sort_kahn_top.sv
// ----------------------------------------------------------------------------
// Topological sort (Kahn) top level
// Edge loader, BFS sort engine and result register.
// ----------------------------------------------------------------------------
// Each edge beat has a read phase (source's tail pointer, target's in-degree)
// and a write phase (list and degree writes) that accepts no beat. On a last
// beat the engine seeds the ready queue, steps each emitted vertex through POP,
// POPRD and EMIT (held while a result waits on back-pressure) and each walked
// edge through EDGE and DEC, then clears all 64 in-degree entries, accepting no
// beat. The user must write the count register only between graphs; the block
// does not enforce it. Edge stores are never cleared: a fill count governs.
`include "topological_sort_kahn_top_macros.svh"
module topological_sort_kahn_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // from_vertex[6:0], to_vertex[13:7]
  input  logic        s_axis_tuser,   // edge_valid
  input  logic        s_axis_tlast,   // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // vertex[6:0]
  output logic [3:0]  m_axis_tuser,   // vertex_valid, cycle_found, order_unique, input_dropped
  output logic        m_axis_tlast    // last_result
);
  localparam int VW = tsk_pkg::VW;
  localparam int EW = tsk_pkg::EW;
  localparam int DW = tsk_pkg::DW;

  tsk_pkg::state_e state_q, state_d;
  logic [6:0] vcount_q;
  logic [6:0] n;
  assign n = (vcount_q > 7'(tsk_pkg::MaxVertices)) ? 7'(tsk_pkg::MaxVertices) : vcount_q;

  // per-vertex flip-flop state (64 entries, read at signal-chosen addresses → memories)
  logic [tsk_pkg::MaxVertices-1:0] hvalid_q;
  logic [DW-1:0] etotal_q;
  logic dropped_q;

  // memories
  logic          deg_we;  logic [VW-1:0] deg_wa, deg_ra; logic [DW-1:0] deg_wd, deg_rd;
  logic          hd_we;   logic [VW-1:0] hd_wa, hd_ra;   logic [EW-1:0] hd_wd, hd_rd;
  logic          tl_we;   logic [VW-1:0] tl_wa, tl_ra;   logic [EW-1:0] tl_wd, tl_rd;
  logic          et_we;   logic [EW-1:0] et_wa, et_ra;   logic [VW-1:0] et_wd, et_rd;
  logic          lk_we;   logic [EW-1:0] lk_wa, lk_ra;   logic [EW-1:0] lk_wd, lk_rd;
  logic          rq_we;   logic [VW-1:0] rq_wa, rq_ra;   logic [VW-1:0] rq_wd, rq_rd;

  tsk_ram #(.Depth(tsk_pkg::MaxVertices), .Width(DW)) u_deg (.clk_i, .we_i(deg_we),
    .waddr_i(deg_wa), .wdata_i(deg_wd), .raddr_i(deg_ra), .rdata_o(deg_rd));
  tsk_ram #(.Depth(tsk_pkg::MaxVertices), .Width(EW)) u_head (.clk_i, .we_i(hd_we),
    .waddr_i(hd_wa), .wdata_i(hd_wd), .raddr_i(hd_ra), .rdata_o(hd_rd));
  tsk_ram #(.Depth(tsk_pkg::MaxVertices), .Width(EW)) u_tail (.clk_i, .we_i(tl_we),
    .waddr_i(tl_wa), .wdata_i(tl_wd), .raddr_i(tl_ra), .rdata_o(tl_rd));
  tsk_ram #(.Depth(tsk_pkg::MaxEdges), .Width(VW)) u_etgt (.clk_i, .we_i(et_we),
    .waddr_i(et_wa), .wdata_i(et_wd), .raddr_i(et_ra), .rdata_o(et_rd));
  tsk_ram #(.Depth(tsk_pkg::MaxEdges), .Width(EW)) u_link (.clk_i, .we_i(lk_we),
    .waddr_i(lk_wa), .wdata_i(lk_wd), .raddr_i(lk_ra), .rdata_o(lk_rd));
  tsk_ram #(.Depth(tsk_pkg::MaxVertices), .Width(VW)) u_rq (.clk_i, .we_i(rq_we),
    .waddr_i(rq_wa), .wdata_i(rq_wd), .raddr_i(rq_ra), .rdata_o(rq_rd));

  // control registers
  logic          ph_q, ph_d;          // load phase: 0 accept, 1 write
  logic [VW-1:0] src_q, src_d, tgt_q, tgt_d;
  logic          last_q, last_d;
  logic [6:0]    idx_q, idx_d;        // seed / clear counter
  logic [6:0]    emit_q, emit_d;
  logic [VW-1:0] qh_q, qh_d;
  logic [6:0]    qf_q, qf_d;
  logic          uniq_q, uniq_d, cyc_q, cyc_d;
  logic [VW-1:0] cur_q, cur_d;
  logic [EW-1:0] e_q, e_d, tail_q, tail_d;
  logic          rd_q, rd_d;
  tsk_pkg::result_t res_q, res_d;
  logic          ov_q, ov_d;

  logic [6:0] in_from, in_to;
  logic in_ev, s_acc, m_acc, cfg_acc;
  assign in_from = s_axis_tdata[6:0];
  assign in_to   = s_axis_tdata[13:7];
  assign in_ev   = s_axis_tuser;
  assign s_axis_tready = (state_q == tsk_pkg::ST_LOAD) && !ph_q;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o = (state_q == tsk_pkg::ST_LOAD) && !ph_q;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, res_q.vertex};
  assign m_axis_tuser  = {res_q.input_dropped, res_q.order_unique, res_q.cycle_found,
                          res_q.vertex_valid};
  assign m_axis_tlast  = res_q.last_result;

  logic edge_ok;
  assign edge_ok = in_ev && (in_from != 7'd0) && (in_from <= n) && (in_to != 7'd0)
                   && (in_to <= n) && (etotal_q < DW'(tsk_pkg::MaxEdges));

  always_comb begin
    state_d = state_q; ph_d = ph_q; src_d = src_q; tgt_d = tgt_q; last_d = last_q;
    idx_d = idx_q; emit_d = emit_q; qh_d = qh_q; qf_d = qf_q; uniq_d = uniq_q;
    cyc_d = cyc_q; cur_d = cur_q; e_d = e_q; tail_d = tail_q; rd_d = rd_q;
    res_d = res_q; ov_d = ov_q;
    deg_we = 1'b0; deg_wa = '0; deg_wd = '0; deg_ra = '0;
    hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = cur_q;
    tl_we = 1'b0; tl_wa = '0; tl_wd = '0; tl_ra = cur_q;
    et_we = 1'b0; et_wa = '0; et_wd = '0; et_ra = e_q;
    lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_ra = e_q;
    rq_we = 1'b0; rq_wa = '0; rq_wd = '0; rq_ra = qh_q;
    if (m_acc) ov_d = 1'b0;
    case (state_q)
      tsk_pkg::ST_LOAD: begin
        if (!ph_q) begin
          if (s_acc) begin
            src_d = VW'(in_from - 7'd1); tgt_d = VW'(in_to - 7'd1);
            last_d = s_axis_tlast;
            tl_ra = VW'(in_from - 7'd1); deg_ra = VW'(in_to - 7'd1);
            if (edge_ok) ph_d = 1'b1;
            else if (s_axis_tlast) begin
              state_d = tsk_pkg::ST_SEED; idx_d = '0; qf_d = '0; qh_d = '0;
              emit_d = '0; uniq_d = 1'b1; cyc_d = 1'b0; rd_d = 1'b0;
            end
          end
        end else begin
          ph_d = 1'b0;
          et_we = 1'b1; et_wa = etotal_q[EW-1:0]; et_wd = tgt_q;
          if (hvalid_q[src_q]) begin
            lk_we = 1'b1; lk_wa = tl_rd; lk_wd = etotal_q[EW-1:0];
          end else begin
            hd_we = 1'b1; hd_wa = src_q; hd_wd = etotal_q[EW-1:0];
          end
          tl_we = 1'b1; tl_wa = src_q; tl_wd = etotal_q[EW-1:0];
          deg_we = 1'b1; deg_wa = tgt_q; deg_wd = deg_rd + DW'(1);
          if (last_q) begin
            state_d = tsk_pkg::ST_SEED; idx_d = '0; qf_d = '0; qh_d = '0;
            emit_d = '0; uniq_d = 1'b1; cyc_d = 1'b0; rd_d = 1'b0;
          end
        end
      end
      tsk_pkg::ST_SEED: begin
        // pipelined: read degree of idx, test previous read
        deg_ra = idx_q[VW-1:0];
        if (rd_q && deg_rd == '0) begin
          rq_we = 1'b1; rq_wa = qf_q[VW-1:0]; rq_wd = VW'(idx_q - 7'd1);
          qf_d = qf_q + 7'd1;
        end
        if (idx_q < n) begin
          rd_d = 1'b1; idx_d = idx_q + 7'd1;
        end else begin
          rd_d = 1'b0; state_d = tsk_pkg::ST_POP;
        end
      end
      tsk_pkg::ST_POP: begin
        if (emit_q >= n) state_d = tsk_pkg::ST_FINAL;
        else if (qf_q == '0) begin
          cyc_d = 1'b1; state_d = tsk_pkg::ST_FINAL;
        end else begin
          if (qf_q > 7'd1) uniq_d = 1'b0;
          state_d = tsk_pkg::ST_POPRD;
        end
      end
      tsk_pkg::ST_POPRD: begin
        cur_d = rq_rd; qh_d = qh_q + VW'(1); qf_d = qf_q - 7'd1;
        hd_ra = rq_rd; tl_ra = rq_rd;
        state_d = tsk_pkg::ST_EMIT;
      end
      tsk_pkg::ST_EMIT: begin
        if (!ov_q || m_acc) begin
          ov_d = 1'b1;
          res_d = '0; res_d.vertex = 7'(cur_q) + 7'd1; res_d.vertex_valid = 1'b1;
          emit_d = emit_q + 7'd1;
          if (emit_q + 7'd1 >= n) begin
            res_d.last_result = 1'b1; res_d.cycle_found = 1'b0;
            res_d.order_unique = uniq_q; res_d.input_dropped = dropped_q;
          end
          if (hvalid_q[cur_q]) begin
            e_d = hd_rd; tail_d = tl_rd; state_d = tsk_pkg::ST_EDGE;
          end else state_d = (emit_q + 7'd1 >= n) ? tsk_pkg::ST_CLEAR : tsk_pkg::ST_POP;
          if (!hvalid_q[cur_q] && emit_q + 7'd1 >= n) idx_d = '0;
        end
      end
      tsk_pkg::ST_EDGE: begin
        // edge target and link available next cycle
        state_d = tsk_pkg::ST_DEC;
        rd_d = 1'b0;
      end
      tsk_pkg::ST_DEC: begin
        if (!rd_q) begin
          deg_ra = et_rd; cur_d = cur_q; tgt_d = et_rd; rd_d = 1'b1;
        end else begin
          rd_d = 1'b0;
          if (deg_rd != '0) begin
            deg_we = 1'b1; deg_wa = tgt_q; deg_wd = deg_rd - DW'(1);
            if (deg_rd == DW'(1)) begin
              rq_we = 1'b1; rq_wa = qh_q + qf_q[VW-1:0]; rq_wd = tgt_q;
              qf_d = qf_q + 7'd1;
            end
          end
          if (e_q == tail_q) begin
            if (emit_q >= n) begin
              state_d = tsk_pkg::ST_CLEAR; idx_d = '0;
            end else state_d = tsk_pkg::ST_POP;
          end else begin
            e_d = lk_rd; state_d = tsk_pkg::ST_EDGE;
          end
        end
      end
      tsk_pkg::ST_FINAL: begin
        if (!ov_q || m_acc) begin
          if (cyc_q || emit_q == '0) begin
            ov_d = 1'b1; res_d = '0; res_d.last_result = 1'b1;
            res_d.cycle_found = cyc_q; res_d.order_unique = uniq_q;
            res_d.input_dropped = dropped_q;
          end
          state_d = tsk_pkg::ST_CLEAR; idx_d = '0;
        end
      end
      tsk_pkg::ST_CLEAR: begin
        deg_we = 1'b1; deg_wa = idx_q[VW-1:0]; deg_wd = '0;
        idx_d = idx_q + 7'd1;
        if (idx_q == 7'(tsk_pkg::MaxVertices - 1)) state_d = tsk_pkg::ST_LOAD;
      end
      default: state_d = tsk_pkg::ST_LOAD;
    endcase
    // keep reads aimed at the current edge / queue head
    if (state_q == tsk_pkg::ST_POP) rq_ra = qh_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsk_pkg::ST_CLEAR; vcount_q <= '0; hvalid_q <= '0; etotal_q <= '0;
      dropped_q <= 1'b0; ph_q <= 1'b0; idx_q <= '0; emit_q <= '0; qh_q <= '0;
      qf_q <= '0; uniq_q <= 1'b1; cyc_q <= 1'b0; rd_q <= 1'b0; ov_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      state_q <= state_d; ph_q <= ph_d; idx_q <= idx_d; emit_q <= emit_d;
      qh_q <= qh_d; qf_q <= qf_d; uniq_q <= uniq_d; cyc_q <= cyc_d; rd_q <= rd_d;
      ov_q <= ov_d; last_q <= last_d;
      if (cfg_acc) vcount_q <= cfg_data_i[6:0];
      if (s_acc && in_ev && !edge_ok) dropped_q <= 1'b1;
      if (state_q == tsk_pkg::ST_LOAD && ph_q) begin
        hvalid_q[src_q] <= 1'b1; etotal_q <= etotal_q + DW'(1);
      end
      if (state_q == tsk_pkg::ST_CLEAR && state_d == tsk_pkg::ST_LOAD) begin
        hvalid_q <= '0; etotal_q <= '0; dropped_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d; tgt_q <= tgt_d; cur_q <= cur_d; e_q <= e_d; tail_q <= tail_d;
    res_q <= res_d;
  end

  `TSK_ASSERT(a_out_hold, clk_i, rst_ni, (ov_q && !m_axis_tready) |=> ov_q)
  `TSK_ASSERT_NEVER(a_qf_over, clk_i, rst_ni, qf_q > 7'(tsk_pkg::MaxVertices))
  `TSK_ASSERT(a_no_in_sort, clk_i, rst_ni, (state_q != tsk_pkg::ST_LOAD) |-> !s_axis_tready)
endmodule

### design/tsk_ram.sv
// ----------------------------------------------------------------------------
// Topological sort RAM
// Generic single-port-write, one-read synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module tsk_ram #(
  parameter int Depth = 64,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Topological sort (Kahn) testbench
// Streams graphs edge by edge into the sorter and checks every emitted vertex
// and the end-of-graph flags against a behavioural sort kept in the bench:
// directed corner graphs, then random graphs under four
// back-pressure/idle mixes.
// ----------------------------------------------------------------------------
module tb;
  localparam int IdleLimit = 40000;
  localparam int SettleCycles = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  topological_sort_kahn_top uut (.*);

  always #10 clk_i = ~clk_i;

  // sorter mirror
  logic [6:0]       vertex_cnt;
  int unsigned      in_deg[tsk_pkg::MaxVertices];
  int               adj[tsk_pkg::MaxVertices][$];
  int               edges_held;
  bit               edge_lost;
  tsk_pkg::result_t order_q[$];

  int errors;
  int idle_pct;
  int stall_pct;
  int beats_sent;
  int idle_cycles;

  function automatic int live_count();
    return (vertex_cnt > tsk_pkg::MaxVertices) ? tsk_pkg::MaxVertices : int'(vertex_cnt);
  endfunction

  function automatic void mirror_clear();
    for (int v = 0; v < tsk_pkg::MaxVertices; v++) begin
      in_deg[v] = 0;
      adj[v].delete();
    end
    edges_held = 0;
    edge_lost = 1'b0;
  endfunction

  function automatic void mirror_edge(int f, int t);
    int n;
    n = live_count();
    if (f < 1 || f > n || t < 1 || t > n || edges_held >= tsk_pkg::MaxEdges) begin
      edge_lost = 1'b1;
    end else begin
      adj[f-1] = {adj[f-1], t - 1};
      in_deg[t-1]++;
      edges_held++;
    end
  endfunction

  function automatic void mirror_sort();
    int               n;
    int               rq[$];
    int               cur;
    int               t;
    bit               uniq;
    bit               cyc;
    tsk_pkg::result_t r;
    tsk_pkg::result_t outq[$];
    n = live_count();
    uniq = 1'b1;
    cyc = 1'b0;
    for (int v = 0; v < n; v++)
      if (in_deg[v] == 0) rq = {rq, v};
    for (int i = 0; i < n; i++) begin
      if (rq.size() == 0) begin
        cyc = 1'b1;
        break;
      end
      if (rq.size() > 1) uniq = 1'b0;
      cur = rq.pop_front();
      r = '0;
      r.vertex = 7'(cur + 1);
      r.vertex_valid = 1'b1;
      outq = {outq, r};
      for (int k = 0; k < adj[cur].size(); k++) begin
        t = adj[cur][k];
        if (in_deg[t] > 0) begin
          in_deg[t]--;
          if (in_deg[t] == 0) rq = {rq, t};
        end
      end
    end
    if (cyc || outq.size() == 0) begin
      r = '0;
      outq = {outq, r};
    end
    r = outq.pop_back();
    r.last_result = 1'b1;
    r.cycle_found = cyc;
    r.order_unique = uniq;
    r.input_dropped = edge_lost;
    outq = {outq, r};
    order_q = {order_q, outq};
    mirror_clear();
  endfunction

  task automatic report(string what, int got, int want);
    $display("MISMATCH t=%0t %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    tsk_pkg::result_t w;
    if (m_axis_tvalid && m_axis_tready) begin
      if (order_q.size() == 0) begin
        report("unexpected result beat", m_axis_tdata[6:0], 0);
      end else begin
        w = order_q.pop_front();
        if (m_axis_tdata[6:0] != w.vertex) report("vertex", m_axis_tdata[6:0], w.vertex);
        if (m_axis_tuser[0] != w.vertex_valid)
          report("vertex_valid", m_axis_tuser[0], w.vertex_valid);
        if (m_axis_tuser[1] != w.cycle_found)
          report("cycle_found", m_axis_tuser[1], w.cycle_found);
        if (m_axis_tuser[2] != w.order_unique)
          report("order_unique", m_axis_tuser[2], w.order_unique);
        if (m_axis_tuser[3] != w.input_dropped)
          report("input_dropped", m_axis_tuser[3], w.input_dropped);
        if (m_axis_tlast != w.last_result) report("last_result", m_axis_tlast, w.last_result);
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("topological_sort_kahn_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(logic [6:0] f, logic [6:0] t, bit ev, bit lst);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, t, f};
    s_axis_tuser <= ev;
    s_axis_tlast <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    if (ev) mirror_edge(f, t);
    if (lst) mirror_sort();
  endtask

  task automatic end_graph();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (order_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_count(logic [6:0] n);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= {1'b0, n};
    do @(posedge clk_i); while (!cfg_ready_o);
    vertex_cnt = n;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_empty_graph();
    send_beat(7'd0, 7'd0, 1'b0, 1'b1);
    end_graph();
    send_beat(7'd1, 7'd1, 1'b1, 1'b0);
    send_beat(7'd127, 7'd127, 1'b1, 1'b1);
    end_graph();
  endtask

  task automatic test_directed();
    write_count(7'd1);
    send_beat(7'd1, 7'd1, 1'b1, 1'b1);
    end_graph();
    write_count(7'd4);
    send_beat(7'd1, 7'd2, 1'b1, 1'b0);
    send_beat(7'd0, 7'd3, 1'b1, 1'b0);
    send_beat(7'd2, 7'd3, 1'b1, 1'b0);
    send_beat(7'd3, 7'd5, 1'b1, 1'b0);
    send_beat(7'd85, 7'd42, 1'b0, 1'b0);
    send_beat(7'd3, 7'd4, 1'b1, 1'b1);
    end_graph();
    send_beat(7'd1, 7'd2, 1'b1, 1'b0);
    send_beat(7'd1, 7'd3, 1'b1, 1'b0);
    send_beat(7'd2, 7'd4, 1'b1, 1'b0);
    send_beat(7'd3, 7'd4, 1'b1, 1'b0);
    send_beat(7'd42, 7'd85, 1'b0, 1'b1);
    end_graph();
    send_beat(7'd2, 7'd3, 1'b1, 1'b0);
    send_beat(7'd3, 7'd2, 1'b1, 1'b1);
    end_graph();
    write_count(7'd64);
    send_beat(7'd64, 7'd1, 1'b1, 1'b0);
    send_beat(7'd1, 7'd64, 1'b1, 1'b0);
    send_beat(7'd63, 7'd2, 1'b1, 1'b1);
    end_graph();
    write_count(7'd127);
    send_beat(7'd64, 7'd65, 1'b1, 1'b0);
    send_beat(7'd64, 7'd2, 1'b1, 1'b1);
    end_graph();
    write_count(7'd65);
    send_beat(7'd0, 7'd0, 1'b0, 1'b1);
    end_graph();
  endtask

  task automatic random_graph();
    int   n;
    int   ne;
    int   rank[tsk_pkg::MaxVertices];
    int   a;
    int   b;
    int   sel;
    bit   noisy;
    logic [6:0] f;
    logic [6:0] t;
    sel = $urandom_range(0, 19);
    if (sel == 0) write_count(7'd0);
    else if (sel == 1) write_count(7'd64);
    else if (sel == 2) write_count(7'($urandom_range(65, 127)));
    else if (sel < 6) write_count(7'($urandom_range(13, 40)));
    else write_count(7'($urandom_range(1, 12)));
    n = live_count();
    noisy = ($urandom_range(0, 99) < 25);
    for (int v = 0; v < tsk_pkg::MaxVertices; v++) rank[v] = $urandom;
    ne = $urandom_range(0, 14);
    for (int i = 0; i <= ne; i++) begin
      if (noisy && $urandom_range(0, 3) == 0) begin
        f = 7'($urandom_range(0, 127));
        t = 7'($urandom_range(0, 127));
      end else if (n == 0) begin
        f = 7'($urandom_range(1, 127));
        t = 7'($urandom_range(1, 127));
      end else begin
        a = $urandom_range(1, n);
        b = $urandom_range(1, n);
        if (!noisy && (rank[a-1] > rank[b-1] || (rank[a-1] == rank[b-1] && a > b))) begin
          f = 7'(b);
          t = 7'(a);
        end else begin
          f = 7'(a);
          t = 7'(b);
        end
        if (!noisy && a == b) t = 7'(0);
      end
      if (!noisy && a == b && n > 0) send_beat(f, 7'($urandom_range(0, 127)), 1'b0, i == ne);
      else send_beat(f, t, (i != ne) || ($urandom_range(0, 1) == 1), i == ne);
    end
    end_graph();
  endtask

  task automatic test_random();
    int pcts[4][2];
    int mark;
    pcts = '{'{0, 0}, '{45, 0}, '{0, 45}, '{21, 21}};
    for (int p = 0; p < 4; p++) begin
      idle_pct = pcts[p][0];
      stall_pct = pcts[p][1];
      mark = beats_sent;
      while (beats_sent - mark < 70) random_graph();
    end
  endtask

  initial begin
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    beats_sent = 0;
    idle_cycles = 0;
    vertex_cnt = '0;
    mirror_clear();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_graph();
    test_directed();
    test_random();
    drain();
    if (errors == 0) begin
      $display("topological_sort_kahn_top verification clean");
    end else begin
      $display("topological_sort_kahn_top verification failed");
    end
    $finish;
  end
endmodule
